// ===== src/chu_pkg.sv =====
// chu_pkg: shared constants, types and functions of the utf-8 context hash unit
// no dependencies; used by the interfaces, the cells, the top level and the checker
package chu_pkg;

  localparam int HASH_W         = 64;
  localparam int MAX_ORDERS     = 7;
  localparam int HASH_ORDERS    = 7;
  localparam int BORDER_ENTRIES = 43;
  localparam int TABLE_SLOTS    = 64;
  localparam int BORDER_N       = (BORDER_ENTRIES > TABLE_SLOTS) ? TABLE_SLOTS : BORDER_ENTRIES;
  localparam int CFG_IDX_W      = 1;
  localparam int LC_W           = 9;

  localparam logic [HASH_W-1:0] MULT_RESET = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [HASH_W-1:0] SEED_RESET = 64'h993D_DEFF_B146_2949;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MULT = 1'b0,
    CFG_SEED = 1'b1
  } cfg_reg_t;

  localparam logic [2:0] CLS_DIGIT  = 3'd0;
  localparam logic [2:0] CLS_LETTER = 3'd1;
  localparam logic [2:0] CLS_ASCII  = 3'd2;
  localparam logic [2:0] CLS_UTF8   = 3'd3;

  localparam logic [1:0] KIND_ALNUM  = 2'd0;
  localparam logic [1:0] KIND_ASCII  = 2'd1;
  localparam logic [1:0] KIND_UTF8   = 2'd2;
  localparam logic [1:0] KIND_BORDER = 2'd3;

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;

  localparam logic [2:0]  LEAD2   = 3'b110;
  localparam logic [3:0]  LEAD3   = 4'b1110;
  localparam logic [4:0]  LEAD4   = 5'b11110;
  localparam logic [1:0]  CONT    = 2'b10;
  localparam logic [23:0] TRI_MASK = 24'hE0C0C0;
  localparam logic [23:0] TRI_PAT  = 24'hE08080;

  localparam logic [23:0] BORDER_TABLE [TABLE_SLOTS] = '{
    24'hEFBC8C, 24'hE79A84, 24'hE38082, 24'hE38081, 24'hEFBC88, 24'hEFBC89, 24'hE59CA8, 24'hE698AF,
    24'hE69C89, 24'hE5928C, 24'hEFBC9A, 24'hE782BA, 24'hE4BBA5, 24'hE3808A, 24'hE4BA86, 24'hE696BC,
    24'hE4B8BA, 24'hE794A8, 24'hE3808C, 24'hE58F8A, 24'hE8808C, 24'hE588B0, 24'hE4BA8E, 24'hE794B1,
    24'hE8A2AB, 24'hE88887, 24'hE4BBBB, 24'hE59091, 24'hE5808B, 24'hE2809C, 24'hE887B3, 24'hE88085,
    24'hE6ADA4, 24'hE585A5, 24'hE4BD86, 24'hEFBC9B, 24'hE4B88E, 24'hE68896, 24'hE5A682, 24'hE5B087,
    24'hE68BAC, 24'hE4BA9B, 24'hE4B894, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000,
    24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000,
    24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000
  };

  typedef struct packed {
    logic en;
    logic shift;
    logic load;
  } cell_ctl_t;

  // low 64 bits of a 64x64 product from three 32x32 partial products
  function automatic logic [HASH_W-1:0] mul64(input logic [HASH_W-1:0] a,
                                             input logic [HASH_W-1:0] b);
    logic [63:0] ll;
    logic [63:0] lh;
    logic [63:0] hl;
    logic [31:0] mid;
    ll    = a[31:0] * b[31:0];
    lh    = a[31:0] * b[63:32];
    hl    = a[63:32] * b[31:0];
    mid   = lh[31:0] + hl[31:0];
    mul64 = ll + {mid, 32'd0};
  endfunction

  function automatic logic is_border(input logic [23:0] tri_bytes);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < BORDER_N; i++) begin
      if (BORDER_TABLE[i] == tri_bytes) hit = 1'b1;
    end
    is_border = hit;
  endfunction

endpackage

// ===== src/chu_if.sv =====
// chu_in_if / chu_out_if: valid-ready channels of the utf-8 context hash unit
// depends on chu_pkg for the hash width
interface chu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface chu_out_if;
  logic                        valid;
  logic                        ready;
  logic [chu_pkg::HASH_W-1:0]  hash_order1;
  logic [chu_pkg::HASH_W-1:0]  hash_order2;
  logic [chu_pkg::HASH_W-1:0]  hash_order3;
  logic [chu_pkg::HASH_W-1:0]  hash_order4;
  logic [chu_pkg::HASH_W-1:0]  hash_order5;
  logic [chu_pkg::HASH_W-1:0]  hash_order6;
  logic [chu_pkg::HASH_W-1:0]  hash_order7;
  logic [chu_pkg::HASH_W-1:0]  word_hash;
  logic [2:0]                  byte_class;
  logic [1:0]                  pending_bytes;

  modport source (output valid, output hash_order1, output hash_order2, output hash_order3,
                  output hash_order4, output hash_order5, output hash_order6,
                  output hash_order7, output word_hash, output byte_class,
                  output pending_bytes, input ready);
  modport sink   (input valid, input hash_order1, input hash_order2, input hash_order3,
                  input hash_order4, input hash_order5, input hash_order6,
                  input hash_order7, input word_hash, input byte_class,
                  input pending_bytes, output ready);
endinterface

// ===== src/chu_cell.sv =====
// chu_cell: one 64-bit hash register with its multiply-add step
// depends on chu_pkg (cell_ctl_t, mul64)
module chu_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  chu_pkg::cell_ctl_t         ctl,
  input  logic [chu_pkg::HASH_W-1:0] left,
  input  logic [chu_pkg::HASH_W-1:0] mult,
  input  logic [chu_pkg::HASH_W-1:0] addend,
  output logic [chu_pkg::HASH_W-1:0] value
);

  logic [chu_pkg::HASH_W-1:0] base;
  logic [chu_pkg::HASH_W-1:0] value_next;

  // (x + c) * m is computed as x * m + c * m, with c * m supplied
  always_comb begin
    base       = ctl.shift ? left : value;
    value_next = ctl.load ? left : chu_pkg::mul64(base, mult) + addend;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      value <= '0;
    end else if (ctl.en) begin
      value <= value_next;
    end
  end

endmodule

// ===== src/utf8_context_hash_update.sv =====
// utf8_context_hash_update: top level of the utf-8 aware order-n context hash unit
// depends on chu_pkg, chu_in_if, chu_out_if and chu_cell
//
// Takes one byte per clock cycle and presents one word per byte after the two input stages
// and the output stage, with no bubbles as long as the output side is ready. The rate is set
// by the multiply-add loop inside each hash cell: every cell folds the new byte into its
// 64-bit hash, and the character hashes pass down the row of cells on each lead byte. While
// the output is stalled the two input stages still fill, so up to two more bytes are taken.
// The user writes the multiplier and the token seed through wr_en, wr_index and wr_data only
// while no byte is in flight; the block itself does not enforce this.
module utf8_context_hash_update (
  input  logic                          clk,
  input  logic                          rst,
  chu_in_if.sink                        bytes,
  chu_out_if.source                     hashes,
  input  logic                          wr_en,
  input  logic [chu_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [chu_pkg::HASH_W-1:0]    wr_data
);

  logic [chu_pkg::HASH_W-1:0] hash_multiplier;
  logic [chu_pkg::HASH_W-1:0] token_seed;

  logic                       v1;
  logic [7:0]                 b1;
  logic                       v2;
  logic [7:0]                 b2;
  logic [chu_pkg::HASH_W-1:0] lcm2;
  logic                       ov;
  logic                       adv1;
  logic                       adv2;

  logic [chu_pkg::LC_W-1:0]          lc1;
  logic [chu_pkg::HASH_W+chu_pkg::LC_W-1:0] lcm_full;

  logic [1:0]  utf8_remaining;
  logic [1:0]  last_token_kind;
  logic [15:0] previous_bytes;
  logic [2:0]  byte_class;
  logic [1:0]  pending_bytes;

  logic        lead;
  logic [1:0]  rem_next;
  logic [2:0]  cls_next;
  logic [1:0]  kind;
  logic [23:0] tri_bytes;
  logic        border;

  chu_pkg::cell_ctl_t char_ctl;
  chu_pkg::cell_ctl_t tok_ctl;

  logic [chu_pkg::HASH_W-1:0] char_hashes [chu_pkg::HASH_ORDERS];
  logic [chu_pkg::HASH_W-1:0] order_out   [chu_pkg::MAX_ORDERS];
  logic [chu_pkg::HASH_W-1:0] token_hash_reg;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hash_multiplier <= chu_pkg::MULT_RESET;
      token_seed      <= chu_pkg::SEED_RESET;
    end else if (wr_en) begin
      case (chu_pkg::cfg_reg_t'(wr_index))
        chu_pkg::CFG_MULT: hash_multiplier <= wr_data;
        chu_pkg::CFG_SEED: token_seed      <= wr_data;
        default: ;
      endcase
    end
  end

  // handshake through the two input stages and the output stage
  assign adv2        = v2 & (~ov | hashes.ready);
  assign adv1        = v1 & (~v2 | adv2);
  assign bytes.ready = ~v1 | adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      ov <= 1'b0;
    end else begin
      if (bytes.ready) v1 <= bytes.valid;
      if (~v2 | adv2) v2 <= v1;
      if (~ov | hashes.ready) ov <= v2;
    end
  end

  // stage 1: byte plus one times the multiplier
  assign lc1      = chu_pkg::LC_W'(b1) + chu_pkg::LC_W'(1);
  assign lcm_full = {{chu_pkg::LC_W{1'b0}}, hash_multiplier}
                  * {{chu_pkg::HASH_W{1'b0}}, lc1};

  always_ff @(posedge clk) begin
    if (bytes.valid & bytes.ready) b1 <= bytes.data_byte;
    if (adv1) begin
      b2   <= b1;
      lcm2 <= lcm_full[chu_pkg::HASH_W-1:0];
    end
  end

  // stage 2: utf-8 decode, class and token boundary
  always_comb begin
    lead = (utf8_remaining == 2'd0);
    if (lead) begin
      if (b2[7:5] == chu_pkg::LEAD2)      rem_next = 2'd1;
      else if (b2[7:4] == chu_pkg::LEAD3) rem_next = 2'd2;
      else if (b2[7:3] == chu_pkg::LEAD4) rem_next = 2'd3;
      else                                rem_next = 2'd0;
    end else begin
      rem_next = utf8_remaining - 2'd1;
      if (b2[7:6] != chu_pkg::CONT) rem_next = 2'd0;
    end

    if (b2 >= chu_pkg::CH_0 && b2 <= chu_pkg::CH_9) begin
      cls_next = chu_pkg::CLS_DIGIT;
    end else if ((b2 >= chu_pkg::CH_LA && b2 <= chu_pkg::CH_LZ) ||
                 (b2 >= chu_pkg::CH_UA && b2 <= chu_pkg::CH_UZ)) begin
      cls_next = chu_pkg::CLS_LETTER;
    end else if (!b2[7]) begin
      cls_next = chu_pkg::CLS_ASCII;
    end else begin
      cls_next = chu_pkg::CLS_UTF8 + {1'b0, rem_next};
    end

    if (cls_next == chu_pkg::CLS_DIGIT || cls_next == chu_pkg::CLS_LETTER) begin
      kind = chu_pkg::KIND_ALNUM;
    end else if (cls_next == chu_pkg::CLS_ASCII) begin
      kind = chu_pkg::KIND_ASCII;
    end else begin
      kind = chu_pkg::KIND_UTF8;
    end

    tri_bytes = {previous_bytes, b2};
    border    = (rem_next == 2'd0) &&
                ((tri_bytes & chu_pkg::TRI_MASK) == chu_pkg::TRI_PAT) &&
                chu_pkg::is_border(tri_bytes);

    char_ctl.en    = adv2;
    char_ctl.shift = lead;
    char_ctl.load  = 1'b0;

    tok_ctl.en    = adv2;
    tok_ctl.shift = (kind != last_token_kind);
    tok_ctl.load  = border;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      utf8_remaining  <= 2'd0;
      last_token_kind <= chu_pkg::KIND_ALNUM;
      previous_bytes  <= '0;
    end else if (adv2) begin
      utf8_remaining  <= rem_next;
      last_token_kind <= border ? chu_pkg::KIND_BORDER : kind;
      previous_bytes  <= tri_bytes[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      byte_class    <= cls_next;
      pending_bytes <= rem_next;
    end
  end

  // row of character hash cells, order 1 restarts from zero on a lead byte
  for (genvar i = 0; i < chu_pkg::HASH_ORDERS; i++) begin : g_cell
    logic [chu_pkg::HASH_W-1:0] left;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_rest
      assign left = char_hashes[i-1];
    end
    chu_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .ctl    (char_ctl),
      .left   (left),
      .mult   (hash_multiplier),
      .addend (lcm2),
      .value  (char_hashes[i])
    );
  end

  chu_cell u_token (
    .clk    (clk),
    .rst    (rst),
    .ctl    (tok_ctl),
    .left   (token_seed),
    .mult   (hash_multiplier),
    .addend (lcm2),
    .value  (token_hash_reg)
  );

  for (genvar k = 0; k < chu_pkg::MAX_ORDERS; k++) begin : g_out
    if (k < chu_pkg::HASH_ORDERS) begin : g_used
      assign order_out[k] = char_hashes[k];
    end else begin : g_unused
      assign order_out[k] = '0;
    end
  end

  assign hashes.valid         = ov;
  assign hashes.hash_order1   = order_out[0];
  assign hashes.hash_order2   = order_out[1];
  assign hashes.hash_order3   = order_out[2];
  assign hashes.hash_order4   = order_out[3];
  assign hashes.hash_order5   = order_out[4];
  assign hashes.hash_order6   = order_out[5];
  assign hashes.hash_order7   = order_out[6];
  assign hashes.word_hash     = token_hash_reg;
  assign hashes.byte_class    = byte_class;
  assign hashes.pending_bytes = pending_bytes;

endmodule

// ===== src/chu_checker.sv =====
// chu_checker: port-level checks of the utf-8 context hash unit, bound to the top level
// depends on chu_pkg for the class codes and the hash width
module chu_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [chu_pkg::HASH_W-1:0] word_hash,
  input logic [2:0]                 byte_class,
  input logic [1:0]                 pending_bytes
);

  // a stalled word keeps its token hash
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(word_hash))
    else $error("word changed while stalled");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("word valid right after reset");

  // ascii bytes never leave continuation bytes pending
  a_ascii_pending: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_class < chu_pkg::CLS_UTF8 |-> pending_bytes == 2'd0)
    else $error("pending count after ascii byte");

  // high bytes report the pending count in their class
  a_utf8_class: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_class >= chu_pkg::CLS_UTF8 |->
      byte_class == chu_pkg::CLS_UTF8 + {1'b0, pending_bytes})
    else $error("class does not match pending count");

endmodule

bind utf8_context_hash_update chu_checker u_chu_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (hashes.valid),
  .out_ready     (hashes.ready),
  .word_hash     (hashes.word_hash),
  .byte_class    (hashes.byte_class),
  .pending_bytes (hashes.pending_bytes)
);

// ===== sim/testbench.sv =====
// testbench: self-checking bench for utf8_context_hash_update
// needs chu_pkg, chu_in_if and chu_out_if; predicts every output word from the byte stream
`timescale 1ns / 100ps

module testbench;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_GAP      = 18;
  localparam int ORDERS       = (chu_pkg::HASH_ORDERS > 7) ? 7
                              : ((chu_pkg::HASH_ORDERS < 1) ? 1 : chu_pkg::HASH_ORDERS);
  localparam int BORDER_LISTED = 43;
  localparam int BORDER_SEARCH = (chu_pkg::BORDER_ENTRIES < BORDER_LISTED)
                               ? chu_pkg::BORDER_ENTRIES : BORDER_LISTED;

  localparam logic [23:0] BORDER_CHARS [BORDER_LISTED] = '{
    24'hEFBC8C, 24'hE79A84, 24'hE38082, 24'hE38081, 24'hEFBC88, 24'hEFBC89, 24'hE59CA8,
    24'hE698AF, 24'hE69C89, 24'hE5928C, 24'hEFBC9A, 24'hE782BA, 24'hE4BBA5, 24'hE3808A,
    24'hE4BA86, 24'hE696BC, 24'hE4B8BA, 24'hE794A8, 24'hE3808C, 24'hE58F8A, 24'hE8808C,
    24'hE588B0, 24'hE4BA8E, 24'hE794B1, 24'hE8A2AB, 24'hE88887, 24'hE4BBBB, 24'hE59091,
    24'hE5808B, 24'hE2809C, 24'hE887B3, 24'hE88085, 24'hE6ADA4, 24'hE585A5, 24'hE4BD86,
    24'hEFBC9B, 24'hE4B88E, 24'hE68896, 24'hE5A682, 24'hE5B087, 24'hE68BAC, 24'hE4BA9B,
    24'hE4B894
  };

  // extremes, each class, each lead length, border chars, a near miss, a malformed tail
  localparam int N_DIRECTED = 26;
  localparam logic [7:0] DIRECTED_BYTES [N_DIRECTED] = '{
    8'h00, 8'hFF, 8'h30, 8'h7A, 8'h41, 8'h61, 8'h21, 8'h7F, 8'hC3, 8'hA9,
    8'hEF, 8'hBC, 8'h8C, 8'hE4, 8'hB8, 8'h94, 8'hE4, 8'hB8, 8'h95,
    8'hF0, 8'h9F, 8'h98, 8'h80, 8'hE3, 8'h41, 8'h80
  };

  typedef struct packed {
    logic [6:0][chu_pkg::HASH_W-1:0] order;
    logic [chu_pkg::HASH_W-1:0]      tok;
    logic [2:0]                      cls;
    logic [1:0]                      pend;
  } hash_word_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          wr_en;
  logic [chu_pkg::CFG_IDX_W-1:0] wr_index;
  logic [chu_pkg::HASH_W-1:0]    wr_data;

  chu_in_if  byte_ch ();
  chu_out_if hash_ch ();

  utf8_context_hash_update u_dut (
    .clk      (clk),
    .rst      (rst),
    .bytes    (byte_ch),
    .hashes   (hash_ch),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  // predictor state
  logic [chu_pkg::HASH_W-1:0] mult;
  logic [chu_pkg::HASH_W-1:0] seed;
  logic [chu_pkg::HASH_W-1:0] ctx_hash [7];
  logic [chu_pkg::HASH_W-1:0] tok_hash;
  logic [1:0]                 cont_left;
  logic [1:0]                 last_kind;
  logic [15:0]                prev_bytes;

  hash_word_t hash_words_due [$];
  int         error_count;
  int         bytes_sent;
  int         cycle_count = 0;
  int         ready_hold = 0;
  bit         in_gaps_on;
  bit         out_gaps_on;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    error_count++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  task automatic fold_byte(input logic [7:0] b);
    logic [chu_pkg::HASH_W-1:0] lc;
    logic [23:0]                trio;
    logic [2:0]                 cls;
    logic [1:0]                 kind;
    logic                       border_hit;
    hash_word_t                 w;
    lc = {56'd0, b} + 64'd1;
    if (cont_left == 2'd0) begin
      for (int i = ORDERS - 1; i >= 1; i--) ctx_hash[i] = (ctx_hash[i-1] + lc) * mult;
      ctx_hash[0] = lc * mult;
      if (b[7:5] == chu_pkg::LEAD2) cont_left = 2'd1;
      else if (b[7:4] == chu_pkg::LEAD3) cont_left = 2'd2;
      else if (b[7:3] == chu_pkg::LEAD4) cont_left = 2'd3;
      else cont_left = 2'd0;
    end else begin
      for (int i = 0; i < ORDERS; i++) ctx_hash[i] = (ctx_hash[i] + lc) * mult;
      cont_left = cont_left - 2'd1;
      if (b[7:6] != chu_pkg::CONT) cont_left = 2'd0;
    end

    if (b >= chu_pkg::CH_0 && b <= chu_pkg::CH_9) cls = chu_pkg::CLS_DIGIT;
    else if ((b >= chu_pkg::CH_LA && b <= chu_pkg::CH_LZ) ||
             (b >= chu_pkg::CH_UA && b <= chu_pkg::CH_UZ)) cls = chu_pkg::CLS_LETTER;
    else if (b < 8'h80) cls = chu_pkg::CLS_ASCII;
    else cls = chu_pkg::CLS_UTF8 + {1'b0, cont_left};

    if (cls == chu_pkg::CLS_DIGIT || cls == chu_pkg::CLS_LETTER) kind = chu_pkg::KIND_ALNUM;
    else if (cls == chu_pkg::CLS_ASCII) kind = chu_pkg::KIND_ASCII;
    else kind = chu_pkg::KIND_UTF8;

    trio = {prev_bytes, b};
    border_hit = 1'b0;
    for (int i = 0; i < BORDER_SEARCH; i++) begin
      if (BORDER_CHARS[i] == trio) border_hit = 1'b1;
    end
    if (cont_left == 2'd0 && (trio & chu_pkg::TRI_MASK) == chu_pkg::TRI_PAT && border_hit) begin
      tok_hash = seed;
      kind = chu_pkg::KIND_BORDER;
    end else begin
      if (kind != last_kind) tok_hash = seed;
      tok_hash = (tok_hash + lc) * mult;
    end
    last_kind = kind;
    prev_bytes = trio[15:0];

    for (int i = 0; i < 7; i++) w.order[i] = (i < ORDERS) ? ctx_hash[i] : '0;
    w.tok = tok_hash;
    w.cls = cls;
    w.pend = cont_left;
    hash_words_due.push_back(w);
  endtask

  // output side: random stalls, compare each word with the oldest prediction
  always @(posedge clk) begin
    hash_word_t seen;
    hash_word_t want;
    int gap;
    if (rst) begin
      hash_ch.ready <= 1'b0;
      ready_hold <= 0;
    end else if (hash_ch.ready && hash_ch.valid) begin
      seen.order[0] = hash_ch.hash_order1;
      seen.order[1] = hash_ch.hash_order2;
      seen.order[2] = hash_ch.hash_order3;
      seen.order[3] = hash_ch.hash_order4;
      seen.order[4] = hash_ch.hash_order5;
      seen.order[5] = hash_ch.hash_order6;
      seen.order[6] = hash_ch.hash_order7;
      seen.tok = hash_ch.word_hash;
      seen.cls = hash_ch.byte_class;
      seen.pend = hash_ch.pending_bytes;
      if (hash_words_due.size() == 0) begin
        report_mismatch("word with no byte waiting for it");
      end else begin
        want = hash_words_due.pop_front();
        for (int i = 0; i < 7; i++) begin
          if (seen.order[i] !== want.order[i])
            report_mismatch($sformatf("hash_order%0d got %h want %h", i + 1,
                                      seen.order[i], want.order[i]));
        end
        if (seen.tok !== want.tok)
          report_mismatch($sformatf("word_hash got %h want %h", seen.tok, want.tok));
        if (seen.cls !== want.cls)
          report_mismatch($sformatf("byte_class got %0d want %0d", seen.cls, want.cls));
        if (seen.pend !== want.pend)
          report_mismatch($sformatf("pending_bytes got %0d want %0d", seen.pend, want.pend));
      end
      gap = out_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
      if (gap != 0) begin
        hash_ch.ready <= 1'b0;
        ready_hold <= gap - 1;
      end
    end else if (!hash_ch.ready) begin
      if (ready_hold == 0) hash_ch.ready <= 1'b1;
      else ready_hold <= ready_hold - 1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = in_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap != 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_ch.valid <= 1'b1;
    byte_ch.data_byte <= b;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    fold_byte(b);
    bytes_sent++;
  endtask

  // waits for the block to drain, then writes both registers
  task automatic write_settings(input logic [chu_pkg::HASH_W-1:0] m,
                                input logic [chu_pkg::HASH_W-1:0] s);
    byte_ch.valid <= 1'b0;
    while (hash_words_due.size() != 0) @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= chu_pkg::CFG_MULT;
    wr_data <= m;
    @(posedge clk);
    wr_index <= chu_pkg::CFG_SEED;
    wr_data <= s;
    @(posedge clk);
    wr_en <= 1'b0;
    mult = m;
    seed = s;
  endtask

  task automatic test_directed_bytes();
    in_gaps_on = 1'b1;
    out_gaps_on = 1'b1;
    foreach (DIRECTED_BYTES[i]) send_byte(DIRECTED_BYTES[i]);
  endtask

  // mostly well-formed utf-8 text with random content, some truncated chars and noise
  task automatic test_random_text(input int n_bytes);
    int          stop_at;
    int          pick;
    logic [31:0] r;
    logic [23:0] ch;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(0, 40) == 0) begin
        in_gaps_on = $urandom_range(0, 2) != 0;
        out_gaps_on = $urandom_range(0, 2) != 0;
      end
      pick = $urandom_range(0, 99);
      r = $urandom;
      if (pick < 30) begin
        pick = $urandom_range(0, 61);
        if (pick < 10) send_byte(chu_pkg::CH_0 + pick[7:0]);
        else if (pick < 36) send_byte(chu_pkg::CH_UA + pick[7:0] - 8'd10);
        else send_byte(chu_pkg::CH_LA + pick[7:0] - 8'd36);
      end else if (pick < 45) begin
        send_byte({1'b0, r[6:0]});
      end else if (pick < 55) begin
        send_byte({chu_pkg::LEAD2, r[4:0]});
        send_byte({chu_pkg::CONT, r[10:5]});
      end else if (pick < 68) begin
        send_byte({chu_pkg::LEAD3, r[3:0]});
        send_byte({chu_pkg::CONT, r[9:4]});
        send_byte({chu_pkg::CONT, r[15:10]});
      end else if (pick < 82) begin
        ch = BORDER_CHARS[$urandom_range(0, BORDER_SEARCH - 1)];
        if (r[31:29] == 3'd0) ch[0] = ~ch[0];
        send_byte(ch[23:16]);
        send_byte(ch[15:8]);
        send_byte(ch[7:0]);
      end else if (pick < 88) begin
        send_byte({chu_pkg::LEAD4, r[2:0]});
        send_byte({chu_pkg::CONT, r[8:3]});
        send_byte({chu_pkg::CONT, r[14:9]});
        send_byte({chu_pkg::CONT, r[20:15]});
      end else if (pick < 94) begin
        // char cut short, next byte lands while continuations are pending
        if (r[31]) begin
          send_byte({chu_pkg::LEAD3, r[3:0]});
          if (r[30]) send_byte({chu_pkg::CONT, r[9:4]});
        end else begin
          send_byte({chu_pkg::LEAD4, r[2:0]});
          send_byte({chu_pkg::CONT, r[8:3]});
          if (r[30]) send_byte({chu_pkg::CONT, r[14:9]});
        end
      end else begin
        send_byte(r[7:0]);
      end
    end
  endtask

  task automatic test_config_settings();
    write_settings('1, '0);
    test_random_text(150);
    write_settings(64'd1, '1);
    test_random_text(150);
    write_settings('0, {$urandom, $urandom});
    test_random_text(100);
    write_settings({$urandom, $urandom} | 64'd1, {$urandom, $urandom});
    test_random_text(300);
    write_settings(chu_pkg::MULT_RESET, chu_pkg::SEED_RESET);
    test_random_text(380);
  endtask

  initial begin
    byte_ch.valid = 1'b0;
    byte_ch.data_byte = 8'd0;
    wr_en = 1'b0;
    wr_index = chu_pkg::CFG_MULT;
    wr_data = '0;
    error_count = 0;
    bytes_sent = 0;
    in_gaps_on = 1'b0;
    out_gaps_on = 1'b0;
    mult = chu_pkg::MULT_RESET;
    seed = chu_pkg::SEED_RESET;
    for (int i = 0; i < 7; i++) ctx_hash[i] = '0;
    tok_hash = '0;
    cont_left = 2'd0;
    last_kind = chu_pkg::KIND_ALNUM;
    prev_bytes = 16'd0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_bytes();
    test_config_settings();

    byte_ch.valid <= 1'b0;
    while (hash_words_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/chu_pkg.sv
src/chu_if.sv
src/chu_cell.sv
src/utf8_context_hash_update.sv
src/chu_checker.sv
sim/testbench.sv
